// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each macro expands to one labeled concurrent assertion in simulation, nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/eadsr_pkg.sv =====
package eadsr_pkg;

	localparam int CFG_W  = 24;
	localparam int LVL_W  = 17;
	localparam int IDX_W  = 3;

	localparam logic [30:0] LN2_Q26 = 31'd46516320;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_GATE    = 3'd4,
		REG_NOTE    = 3'd5
	} reg_idx_t;

	// envelope segment of the current sample
	typedef enum logic [2:0] {
		SEG_ATT,
		SEG_DEC,
		SEG_REL,
		SEG_FLAT,
		SEG_ZERO
	} seg_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETUP,
		OP_DIV,
		OP_MOD,
		OP_MUL_T,
		OP_MUL_R,
		OP_ACC,
		OP_SCALE,
		OP_LVL_MUL,
		OP_FINISH
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_DIV,
		S_MOD,
		S_MULT,
		S_MULR,
		S_ACC,
		S_SCALE,
		S_LVL,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic ezero;
		logic out_free;
	} sts_t;

	// reciprocal of i for exact floor(x / i), x below 2^31: M = ceil(2^N / i)
	function automatic logic [31:0] recip_mul(input logic [3:0] i);
		logic [31:0] m;
		begin
			case (i)
				4'd3, 4'd6, 4'd12: m = 32'd2863311531;
				4'd5, 4'd10:        m = 32'd3435973837;
				4'd7:               m = 32'd2454267027;
				4'd9:               m = 32'd3817748708;
				4'd11:              m = 32'd3123612579;
				default:            m = 32'd2147483648;
			endcase
			return m;
		end
	endfunction

	// N - 31 for the reciprocal above
	function automatic logic [2:0] recip_sh(input logic [3:0] i);
		logic [2:0] s;
		begin
			case (i)
				4'd2:                     s = 3'd1;
				4'd3, 4'd4:               s = 3'd2;
				4'd5, 4'd6, 4'd7, 4'd8:   s = 3'd3;
				4'd9, 4'd10, 4'd11, 4'd12: s = 3'd4;
				default:                  s = 3'd0;
			endcase
			return s;
		end
	endfunction

endpackage

// ===== rtl/core/exponential_adsr_envelope_top.sv =====
// Channel   Dir  Signals                                  Contents (low bit first)
// s_axis    in   s_axis_tvalid/tready/tdata[7:0]          restart
// m_axis    out  m_axis_tvalid/tready/tdata[23:0]/tlast   level[16:0]; tlast = last_sample
//                m_axis_tuser[0:0]                        finished
// cfg       in   cfg_valid/ready/addr[2:0]/wdata[23:0]    register index, value
//
// One item at a time; the result sits in an output register so the next item is taken
// while it waits. An item before the first restart goes from setup to finish, a sample
// with no exponential (flat sustain, tail, or a spent curve) to the level multiply, and
// a full exponential through restoring division, ln 2 reduction and 12 series terms on
// the series multipliers. arst_n clears config, note state and output valid; no clearing
// pass. A stalled output holds the block in its last state until the result is taken.
module exponential_adsr_envelope_top #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [16:0] level
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser,   // [0] finished
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	eadsr_pkg::cmd_t cmd;
	eadsr_pkg::sts_t sts;

	eadsr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	eadsr_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_tdata      (s_axis_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== rtl/core/eadsr_ctrl.sv =====
module eadsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  eadsr_pkg::sts_t   sts,
	output eadsr_pkg::cmd_t   cmd
);

	eadsr_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eadsr_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// sequence one item through the datapath
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		s_axis_tready = 1'b0;
		cmd.op        = eadsr_pkg::OP_NONE;
		cmd.cnt       = cnt_q[3:0];
		unique case (state_q)
			eadsr_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.op  = eadsr_pkg::OP_LOAD;
					state_d = eadsr_pkg::S_SETUP;
				end
			end
			eadsr_pkg::S_SETUP: begin
				cmd.op = eadsr_pkg::OP_SETUP;
				cnt_d  = '0;
				if (!sts.active) begin
					state_d = eadsr_pkg::S_FINISH;
				end else if (sts.ezero) begin
					state_d = eadsr_pkg::S_LVL;
				end else begin
					state_d = eadsr_pkg::S_DIV;
				end
			end
			eadsr_pkg::S_DIV: begin
				cmd.op = eadsr_pkg::OP_DIV;
				if (cnt_q == 5'd30) begin
					cnt_d   = 5'd5;
					state_d = eadsr_pkg::S_MOD;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			eadsr_pkg::S_MOD: begin
				cmd.op = eadsr_pkg::OP_MOD;
				if (cnt_q == 5'd0) begin
					cnt_d   = 5'd1;
					state_d = eadsr_pkg::S_MULT;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			eadsr_pkg::S_MULT: begin
				cmd.op  = eadsr_pkg::OP_MUL_T;
				state_d = eadsr_pkg::S_MULR;
			end
			eadsr_pkg::S_MULR: begin
				cmd.op  = eadsr_pkg::OP_MUL_R;
				state_d = eadsr_pkg::S_ACC;
			end
			eadsr_pkg::S_ACC: begin
				cmd.op = eadsr_pkg::OP_ACC;
				if (cnt_q == 5'd12) begin
					state_d = eadsr_pkg::S_SCALE;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = eadsr_pkg::S_MULT;
				end
			end
			eadsr_pkg::S_SCALE: begin
				cmd.op  = eadsr_pkg::OP_SCALE;
				state_d = eadsr_pkg::S_LVL;
			end
			eadsr_pkg::S_LVL: begin
				cmd.op  = eadsr_pkg::OP_LVL_MUL;
				state_d = eadsr_pkg::S_FINISH;
			end
			eadsr_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = eadsr_pkg::OP_FINISH;
					state_d = eadsr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = eadsr_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/eadsr_dp.sv =====
`include "assert_macros.svh"

module eadsr_dp #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [eadsr_pkg::IDX_W-1:0]         cfg_addr,
	input  logic [eadsr_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [7:0]                          in_tdata,
	input  eadsr_pkg::cmd_t                     cmd,
	output eadsr_pkg::sts_t                     sts,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [23:0]                         m_axis_tdata,
	output logic                                m_axis_tlast,
	output logic [0:0]                          m_axis_tuser
);

	localparam int XW = ((COUNT_WIDTH > eadsr_pkg::CFG_W) ? COUNT_WIDTH : eadsr_pkg::CFG_W) + 1;
	localparam int FW = (XW + 3 > 30) ? XW + 3 : 30;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int CW = eadsr_pkg::CFG_W;
	localparam int LW = eadsr_pkg::LVL_W;

	// configuration and note state
	logic [CW-1:0] attack_q, decay_q, release_q, gate_q, note_q;
	logic [LW-1:0] sustain_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [LW-1:0] held_q;
	logic active_q;

	// working registers
	eadsr_pkg::seg_t seg_q;
	logic [CW-1:0] len_q, rem_q;
	logic [4:0]  low_q;
	logic [30:0] quo_q;
	logic [5:0]  m_q;
	logic [30:0] term_q;
	logic [31:0] sum_q;
	logic [63:0] prod_q;
	logic [30:0] e_q;

	// result register
	logic          out_valid_q;
	logic [LW-1:0] out_level_q;
	logic          out_last_q, out_fin_q;

	// comparison operands
	logic [XW-1:0] n_x, a_x, d_x, r_x, g_x, nl_x, n1_x;
	logic [LW-1:0] s_c;

	always_comb begin
		n_x  = XW'(count_q);
		a_x  = XW'(attack_q);
		d_x  = XW'(decay_q);
		r_x  = XW'(release_q);
		g_x  = XW'(gate_q);
		nl_x = XW'(note_q);
		n1_x = n_x + XW'(1);
		s_c  = (sustain_q > eadsr_pkg::ONE_Q16) ? eadsr_pkg::ONE_Q16 : sustain_q;
	end

	// pick segment, exponent numerator and time constant
	eadsr_pkg::seg_t seg_c;
	logic [XW-1:0] k_c;
	logic [CW-1:0] len_c;
	logic [FW-1:0] fivek_c, lim_c;
	logic ezero_c;

	always_comb begin
		if (n_x >= g_x && r_x != '0) begin
			seg_c = eadsr_pkg::SEG_REL;
		end else if (n_x < a_x) begin
			seg_c = eadsr_pkg::SEG_ATT;
		end else if (n_x < g_x) begin
			seg_c = (d_x != '0) ? eadsr_pkg::SEG_DEC : eadsr_pkg::SEG_FLAT;
		end else begin
			seg_c = eadsr_pkg::SEG_ZERO;
		end
		case (seg_c)
			eadsr_pkg::SEG_REL: begin
				k_c   = n_x - g_x + XW'(1);
				len_c = release_q;
			end
			eadsr_pkg::SEG_ATT: begin
				k_c   = n_x;
				len_c = attack_q;
			end
			default: begin
				k_c   = n_x - a_x;
				len_c = decay_q;
			end
		endcase
		fivek_c = FW'({k_c, 2'b00}) + FW'(k_c);
		lim_c   = FW'({len_c, 5'b00000});
		ezero_c = (fivek_c >= lim_c) || seg_c == eadsr_pkg::SEG_FLAT
			|| seg_c == eadsr_pkg::SEG_ZERO;
	end

	// restoring division step
	logic [CW:0] rs_c;
	logic        div_ge_c;
	always_comb begin
		rs_c     = {rem_q, low_q[4]};
		div_ge_c = rs_c >= {1'b0, len_q};
	end

	// range reduction step by ln 2
	logic [30:0] lsh_c;
	logic        mod_ge_c;
	always_comb begin
		lsh_c    = eadsr_pkg::LN2_Q26 << cmd.cnt[2:0];
		mod_ge_c = quo_q >= lsh_c;
	end

	// series multiplies
	logic [29:0] t_c;
	logic [60:0] mt_c;
	logic [62:0] mr_c;
	logic [5:0]  shamt_c;
	logic [63:0] tq_c;
	always_comb begin
		t_c     = {quo_q[25:0], 4'b0000};
		mt_c    = term_q * t_c;
		mr_c    = prod_q[60:30] * eadsr_pkg::recip_mul(cmd.cnt);
		shamt_c = 6'd31 + 6'(eadsr_pkg::recip_sh(cmd.cnt));
		tq_c    = prod_q >> shamt_c;
	end

	// level scaling multiply
	logic [LW-1:0] lm_a_c;
	logic [47:0]   lm_c;
	always_comb begin
		lm_a_c = (seg_q == eadsr_pkg::SEG_REL) ? held_q : (eadsr_pkg::ONE_Q16 - s_c);
		lm_c   = lm_a_c * e_q;
	end

	// final level, rounded and limited
	logic [31:0] att_c;
	logic [49:0] dec_c;
	logic [48:0] rel_c;
	logic [19:0] raw_c;
	logic [LW-1:0] lvl_c;
	always_comb begin
		att_c = eadsr_pkg::ONE_Q30 - 32'(e_q) + 32'd8192;
		dec_c = {3'b000, s_c, 30'd0} + 50'(prod_q[47:0]) + 50'd536870912;
		rel_c = 49'(prod_q[47:0]) + 49'd536870912;
		case (seg_q)
			eadsr_pkg::SEG_ATT: raw_c = 20'(att_c[31:14]);
			eadsr_pkg::SEG_DEC: raw_c = dec_c[49:30];
			eadsr_pkg::SEG_REL: raw_c = 20'(rel_c[48:30]);
			eadsr_pkg::SEG_FLAT: raw_c = 20'(s_c);
			default: raw_c = '0;
		endcase
		lvl_c = (raw_c > 20'(eadsr_pkg::ONE_Q16)) ? eadsr_pkg::ONE_Q16 : raw_c[LW-1:0];
	end

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			sustain_q <= '0;
			release_q <= '0;
			gate_q    <= '0;
			note_q    <= '0;
		end else if (cfg_valid) begin
			unique case (eadsr_pkg::reg_idx_t'(cfg_addr))
				eadsr_pkg::REG_ATTACK:  attack_q  <= cfg_wdata;
				eadsr_pkg::REG_DECAY:   decay_q   <= cfg_wdata;
				eadsr_pkg::REG_SUSTAIN: sustain_q <= cfg_wdata[LW-1:0];
				eadsr_pkg::REG_RELEASE: release_q <= cfg_wdata;
				eadsr_pkg::REG_GATE:    gate_q    <= cfg_wdata;
				eadsr_pkg::REG_NOTE:    note_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// note state: restart on load, advance on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			held_q   <= '0;
			active_q <= 1'b0;
		end else if (cmd.op == eadsr_pkg::OP_LOAD && in_tdata[0]) begin
			count_q  <= '0;
			held_q   <= '0;
			active_q <= 1'b1;
		end else if (cmd.op == eadsr_pkg::OP_FINISH && active_q) begin
			if (gate_q != '0 && n1_x == g_x) begin
				held_q <= lvl_c;
			end
			if (count_q != CNT_MAX) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == eadsr_pkg::OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == eadsr_pkg::OP_FINISH) begin
			if (!active_q || n_x >= nl_x) begin
				out_level_q <= '0;
				out_last_q  <= 1'b0;
				out_fin_q   <= 1'b1;
			end else begin
				out_level_q <= lvl_c;
				out_last_q  <= (n1_x == nl_x);
				out_fin_q   <= 1'b0;
			end
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			eadsr_pkg::OP_SETUP: begin
				seg_q <= seg_c;
				len_q <= len_c;
				rem_q <= fivek_c[28:5];
				low_q <= fivek_c[4:0];
				quo_q <= '0;
				m_q   <= '0;
				e_q   <= '0;
			end
			eadsr_pkg::OP_DIV: begin
				rem_q <= div_ge_c ? CW'(rs_c - {1'b0, len_q}) : rs_c[CW-1:0];
				quo_q <= {quo_q[29:0], div_ge_c};
				low_q <= {low_q[3:0], 1'b0};
			end
			eadsr_pkg::OP_MOD: begin
				if (mod_ge_c) begin
					quo_q <= quo_q - lsh_c;
				end
				m_q[cmd.cnt[2:0]] <= mod_ge_c;
				term_q <= eadsr_pkg::ONE_Q30[30:0];
				sum_q  <= eadsr_pkg::ONE_Q30;
			end
			eadsr_pkg::OP_MUL_T: begin
				prod_q <= 64'(mt_c);
			end
			eadsr_pkg::OP_MUL_R: begin
				prod_q <= 64'(mr_c);
			end
			eadsr_pkg::OP_ACC: begin
				term_q <= tq_c[30:0];
				sum_q  <= cmd.cnt[0] ? sum_q - 32'(tq_c[30:0]) : sum_q + 32'(tq_c[30:0]);
			end
			eadsr_pkg::OP_SCALE: begin
				e_q <= sum_q[30:0] >> m_q;
			end
			eadsr_pkg::OP_LVL_MUL: begin
				prod_q <= 64'(lm_c);
			end
			default: ;
		endcase
	end

	assign sts.active   = active_q;
	assign sts.ezero    = ezero_c;
	assign sts.out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0000000, out_level_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_fin_q;

	`ASSERT_IMP(a_level_range, clk, arst_n, out_valid_q, out_level_q <= eadsr_pkg::ONE_Q16)
	`ASSERT_IMP(a_fin_quiet, clk, arst_n, out_valid_q && out_fin_q, out_level_q == '0 && !out_last_q)
	`ASSERT_IMP(a_div_rem, clk, arst_n, cmd.op == eadsr_pkg::OP_DIV, rem_q < len_q)
	`ASSERT_IMP(a_mod_done, clk, arst_n, cmd.op == eadsr_pkg::OP_MUL_T, quo_q < eadsr_pkg::LN2_Q26)
	`ASSERT_NXT(a_count_sat, clk, arst_n, cmd.op == eadsr_pkg::OP_FINISH && active_q && count_q == CNT_MAX, count_q == CNT_MAX)

endmodule

// ===== dv/exponential_adsr_envelope_checker.sv =====
`timescale 1ns / 100ps

module exponential_adsr_envelope_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [16:0] level;
		logic        last_sample;
		logic        finished;
	} env_sample_t;

	localparam longint unsigned Q30     = 64'd1 << 30;
	localparam longint unsigned LN2     = 64'd46516320;
	localparam longint unsigned CNT_MAX = (64'd1 << 24) - 1;

	// mirrored registers and envelope state
	longint unsigned attack_r, decay_r, sustain_r, release_r, gate_r, note_r;
	longint unsigned count_r, held_r;
	logic            running;
	env_sample_t     level_queue[$];

	// exp(-5k/len) in Q30, series evaluation after ln 2 reduction
	function automatic longint unsigned exp_q30(longint unsigned k, longint unsigned len);
		longint unsigned q, m, r, t, term, sum;
		begin
			if (len == 0 || 5 * k >= 32 * len)
				return 0;
			q = ((5 * k) << 26) / len;
			m = q / LN2;
			r = q - m * LN2;
			t = r << 4;
			term = Q30;
			sum = Q30;
			for (int i = 1; i <= 12; i++) begin
				term = (term * t) >> 30;
				term = term / i;
				if (i % 2)
					sum = sum - term;
				else
					sum = sum + term;
			end
			if (m >= 63)
				return 0;
			return sum >> m;
		end
	endfunction

	function automatic longint unsigned clip_q16(longint unsigned v);
		return (v > 65536) ? 65536 : v;
	endfunction

	// envelope level at sample n from the current registers
	function automatic longint unsigned envelope_at(longint unsigned n);
		longint unsigned e, s;
		begin
			s = (sustain_r > 65536) ? 65536 : sustain_r;
			if (n >= gate_r && release_r != 0) begin
				e = exp_q30(n - gate_r + 1, release_r);
				return clip_q16((held_r * e + (64'd1 << 29)) >> 30);
			end
			if (n < attack_r) begin
				e = exp_q30(n, attack_r);
				return clip_q16((Q30 - e + (64'd1 << 13)) >> 14);
			end
			if (n < gate_r) begin
				if (decay_r == 0)
					return s;
				e = exp_q30(n - attack_r, decay_r);
				return clip_q16(((s << 30) + (65536 - s) * e + (64'd1 << 29)) >> 30);
			end
			return 0;
		end
	endfunction

	assign pending = level_queue.size();

	always @(posedge clk or negedge arst_n) begin
		env_sample_t     want, got;
		longint unsigned n, lvl;
		if (!arst_n) begin
			attack_r = 0; decay_r = 0; sustain_r = 0;
			release_r = 0; gate_r = 0; note_r = 0;
			count_r = 0; held_r = 0; running = 1'b0;
			errors = 0;
			level_queue.delete();
		end else begin
			// mirror register writes
			if (cfg_valid && cfg_ready) begin
				case (eadsr_pkg::reg_idx_t'(cfg_addr))
					eadsr_pkg::REG_ATTACK:  attack_r  = cfg_wdata;
					eadsr_pkg::REG_DECAY:   decay_r   = cfg_wdata;
					eadsr_pkg::REG_SUSTAIN: sustain_r = cfg_wdata[16:0];
					eadsr_pkg::REG_RELEASE: release_r = cfg_wdata;
					eadsr_pkg::REG_GATE:    gate_r    = cfg_wdata;
					eadsr_pkg::REG_NOTE:    note_r    = cfg_wdata;
					default: ;
				endcase
			end
			// predict the sample for an accepted tick
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata[0]) begin
					count_r = 0;
					held_r = 0;
					running = 1'b1;
				end
				if (!running) begin
					want = '{level: 17'd0, last_sample: 1'b0, finished: 1'b1};
				end else begin
					n = count_r;
					lvl = envelope_at(n);
					if (gate_r != 0 && n == gate_r - 1)
						held_r = lvl;
					if (n >= note_r)
						want = '{level: 17'd0, last_sample: 1'b0, finished: 1'b1};
					else
						want = '{level: lvl[16:0], last_sample: (n == note_r - 1),
							finished: 1'b0};
					if (n < CNT_MAX)
						n++;
					count_r = n;
				end
				level_queue.push_back(want);
			end
			// compare an accepted sample with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{level: m_axis_tdata[16:0], last_sample: m_axis_tlast,
					finished: m_axis_tuser[0]};
				if (level_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected sample: level %0d last %0b finished %0b",
							got.level, got.last_sample, got.finished);
				end else begin
					want = level_queue.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: level %0d/%0d last %0b/%0b finished %0b/%0b",
								want.level, got.level, want.last_sample, got.last_sample,
								want.finished, got.finished);
					end
				end
			end
		end
	end

endmodule

// ===== dv/exponential_adsr_envelope_top_tb.sv =====
`timescale 1ns / 100ps

module exponential_adsr_envelope_top_tb;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;    // [0] restart
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;    // [16:0] level
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;    // [0] finished
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_addr;
	logic [23:0] cfg_wdata;
	int          errors;
	int          pending;
	int          cycles;
	int          ready_hold;
	bit          no_gaps;

	exponential_adsr_envelope_top DUT (.*);

	exponential_adsr_envelope_checker checker_i (.*);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int p;
		begin
			p = $urandom_range(0, 99);
			if (no_gaps || p < 70)
				return 0;
			if (p < 95)
				return $urandom_range(1, 3);
			return $urandom_range(20, 120);
		end
	endfunction

	// sink stalls
	always @(posedge clk) begin
		int next_hold;
		next_hold = ready_hold;
		if (ready_hold > 0)
			next_hold = ready_hold - 1;
		else if (m_axis_tvalid)
			next_hold = gap_len();
		ready_hold <= next_hold;
		m_axis_tready <= (next_hold == 0);
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// hold valid across back-to-back writes; the caller drops it
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic send_tick(input logic restart);
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, restart};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_envelope(input logic [23:0] a, input logic [23:0] d, input logic [23:0] s,
		input logic [23:0] r, input logic [23:0] g, input logic [23:0] n);
		write_reg(eadsr_pkg::REG_ATTACK, a);
		write_reg(eadsr_pkg::REG_DECAY, d);
		write_reg(eadsr_pkg::REG_SUSTAIN, s);
		write_reg(eadsr_pkg::REG_RELEASE, r);
		write_reg(eadsr_pkg::REG_GATE, g);
		write_reg(eadsr_pkg::REG_NOTE, n);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_len();
		int p;
		begin
			p = $urandom_range(0, 99);
			if (p < 70)
				return 24'($urandom_range(0, 40));
			if (p < 92)
				return 24'($urandom_range(0, 400));
			return 24'($urandom_range(0, 24'hFFFFFF));
		end
	endfunction

	// note with a restart up front, occasional retrigger
	task automatic play(input int count);
		send_tick(1'b1);
		for (int i = 1; i < count; i++)
			send_tick($urandom_range(0, 49) == 0);
	endtask

	initial begin
		logic [23:0] nl;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = 3'd0;
		cfg_wdata = 24'd0;
		cycles = 0;
		ready_hold = 0;
		no_gaps = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks before the first restart, then reset registers
		repeat (3) send_tick(1'b0);
		play(4);
		drain();

		// no release, zero decay: attack outlasts gate, so the level drops to zero after attack
		set_envelope(24'd8, 24'd0, 24'd40000, 24'd0, 24'd4, 24'd12);
		play(14);
		drain();
		// gate zero, sustain above full scale, unused register indexes
		write_reg(3'd6, 24'hFFFFFF);
		write_reg(3'd7, 24'h000000);
		set_envelope(24'd0, 24'd5, 24'h1FFFF, 24'd6, 24'd0, 24'd10);
		play(12);
		drain();
		// held level captured beyond the note end
		set_envelope(24'd3, 24'd4, 24'd20000, 24'd5, 24'd20, 24'd10);
		play(25);
		drain();
		// full scale everything
		set_envelope(24'hFFFFFF, 24'hFFFFFF, 24'd65536, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		play(8);
		drain();

		// random envelopes
		for (int ph = 0; ph < 8; ph++) begin
			no_gaps = (ph == 3);
			nl = rand_len();
			set_envelope(rand_len(), rand_len(),
				24'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
					: $urandom_range(0, 65536)),
				rand_len(),
				($urandom_range(0, 9) == 0) ? rand_len() : 24'($urandom_range(0, nl + 2)),
				nl);
			play(240);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
